/* sv/sorted_insertion_table_defines.svh */
// assertion macros shared by the table's checks
`ifndef SORTED_INSERTION_TABLE_DEFINES_SVH
`define SORTED_INSERTION_TABLE_DEFINES_SVH

// same-cycle implication on clk, off while in reset
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while in reset
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sit_pkg.sv */
package sit_pkg;

    localparam int CAPACITY   = 16;
    localparam int TEXT_CHARS = 8;

    localparam int KEY_W  = 32;
    localparam int IN_TEXT_W = 64;
    localparam int TEXT_W = 8 * TEXT_CHARS;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_RECORD   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_ROT  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TEXT_W-1:0]       first_text;
        logic [TEXT_W-1:0]       second_text;
    } rec_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic [1:0]              op;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] key;
    } cell_ctl_t;

endpackage

/* sv/sit_cell.sv */
module sit_cell
    import sit_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  cell_ctl_t        ctl,
    input  rec_t             new_rec,
    input  logic             prev_less,
    input  rec_t             left_rec,
    input  rec_t             right_rec,
    input  rec_t             wrap_rec,
    output logic             less,
    output rec_t             rec
);

    rec_t rec_reg;
    rec_t rec_next;
    logic occupied;
    logic is_tail;

    // occupancy and tail position from the shared count
    assign occupied = CNT_W'(idx) < ctl.count;
    assign is_tail  = (CNT_W'(idx) + CNT_W'(1)) == ctl.count;

    // stored key sorts ahead of the incoming key
    assign less = occupied && (rec_reg.key < ctl.key);

    // insert shifts right from the slot, read-out rotates left over the filled cells
    always_comb
    begin
        rec_next = rec_reg;
        case (ctl.op)
            OP_INS:
            begin
                if (!less)
                begin
                    rec_next = prev_less ? new_rec : left_rec;
                end
            end
            OP_ROT:
            begin
                if (occupied)
                begin
                    rec_next = is_tail ? wrap_rec : right_rec;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

/* sv/sorted_insertion_table.sv */
// sorted table of records held in a chain of compare-and-shift cells
// insert: status beat the cycle after start; a new start can follow at once
// read-out: busy in the read state; each record beat is registered out of it, one per cycle
// empty read-out or full insert: one status beat the cycle after start
// rst_n (async, active low) empties the table; record contents are not cleared
// the receiver cannot stall: each beat is shown for exactly one cycle on valid
module sorted_insertion_table
    import sit_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic signed [KEY_W-1:0]     key,
    input  logic [IN_TEXT_W-1:0]        first_text,
    input  logic [IN_TEXT_W-1:0]        second_text,
    output logic                        valid,
    output logic [1:0]                  status,
    output logic signed [KEY_W-1:0]     out_key,
    output logic [IN_TEXT_W-1:0]        out_first_text,
    output logic [IN_TEXT_W-1:0]        out_second_text,
    output logic                        last
);

`include "sorted_insertion_table_defines.svh"

    localparam logic SM_IDLE = 1'b0;
    localparam logic SM_READ = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             valid_reg, valid_next;
    logic [1:0]       status_reg, status_next;
    rec_t             out_rec_reg, out_rec_next;
    logic             last_reg, last_next;

    logic      accept;
    logic      full;
    logic      ins_go;
    logic      rd_last;
    cell_ctl_t ctl;
    rec_t      new_rec;
    rec_t      cell_rec [CAPACITY];
    logic      cell_less [CAPACITY];

    assign accept  = start && !busy;
    assign full    = count_reg == CNT_W'(CAPACITY);
    assign ins_go  = accept && cmd == CMD_INSERT && !full;
    assign rd_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;

    // incoming record, texts cut to the stored width
    assign new_rec.key         = key;
    assign new_rec.first_text  = first_text[TEXT_W-1:0];
    assign new_rec.second_text = second_text[TEXT_W-1:0];

    // broadcast to the chain
    always_comb
    begin
        ctl.count = count_reg;
        ctl.key   = key;
        if (state_reg == SM_READ)
        begin
            ctl.op = OP_ROT;
        end
        else if (ins_go)
        begin
            ctl.op = OP_INS;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end
    end

    // chain of cells, cell 0 holds the smallest key
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic prev_less;
        rec_t left_rec;
        rec_t right_rec;

        if (g == 0)
        begin : g_head
            assign prev_less = 1'b1;
            assign left_rec  = '0;
        end
        else
        begin : g_body
            assign prev_less = cell_less[g-1];
            assign left_rec  = cell_rec[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign right_rec = '0;
        end
        else
        begin : g_mid
            assign right_rec = cell_rec[g+1];
        end

        sit_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(g)),
            .ctl       (ctl),
            .new_rec   (new_rec),
            .prev_less (prev_less),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .wrap_rec  (cell_rec[0]),
            .less      (cell_less[g]),
            .rec       (cell_rec[g])
        );
    end

    // command sequencing and result beats
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        valid_next   = 1'b0;
        status_next  = ST_INSERTED;
        out_rec_next = '0;
        last_next    = 1'b0;
        case (state_reg)
            SM_READ:
            begin
                valid_next   = 1'b1;
                status_next  = ST_RECORD;
                out_rec_next = cell_rec[0];
                last_next    = rd_last;
                rd_idx_next  = rd_idx_reg + IDX_W'(1);
                if (rd_last)
                begin
                    state_next = SM_IDLE;
                end
            end
            SM_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_INSERT)
                    begin
                        valid_next = 1'b1;
                        last_next  = 1'b1;
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_INSERTED;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        valid_next  = 1'b1;
                        last_next   = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next  = SM_READ;
                        rd_idx_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = SM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SM_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        out_rec_reg <= out_rec_next;
        last_reg    <= last_next;
    end

    assign busy            = state_reg == SM_READ;
    assign valid           = valid_reg;
    assign status          = status_reg;
    assign out_key         = out_rec_reg.key;
    assign out_first_text  = IN_TEXT_W'(out_rec_reg.first_text);
    assign out_second_text = IN_TEXT_W'(out_rec_reg.second_text);
    assign last            = last_reg;

    // checks
    `SIT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SIT_ASSERT_NOW(a_read_nonempty, busy, count_reg != '0, "read-out on an empty table")
    `SIT_ASSERT_NEXT(a_insert_count, ins_go, count_reg == $past(count_reg) + CNT_W'(1), "no count step")
    `SIT_ASSERT_NOW(a_last_record_idle, valid && status == ST_RECORD && last, !busy, "busy after last")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sit_pkg::*;

    localparam int ITEM_TARGET = 150;
    localparam int QUIET_TAIL  = 30;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    // one result beat as the block shows it
    typedef struct {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic [IN_TEXT_W-1:0]    first_text;
        logic [IN_TEXT_W-1:0]    second_text;
        logic                    last;
    } table_beat_t;

    // sorted record table mirror and the beats it still owes
    class record_table_scoreboard;
        rec_t        rows[$];
        table_beat_t owed_beats[$];
        int          errors = 0;

        function void note_command(logic c, logic signed [KEY_W-1:0] k,
                                   logic [IN_TEXT_W-1:0] f, logic [IN_TEXT_W-1:0] s);
            rec_t        r;
            table_beat_t b;
            int          pos;
            b = '{status: ST_INSERTED, key: '0, first_text: '0, second_text: '0, last: 1'b1};
            if (c == CMD_INSERT) begin
                if (rows.size() >= CAPACITY) begin
                    b.status = ST_FULL;
                end
                else begin
                    r.key         = k;
                    r.first_text  = f[TEXT_W-1:0];
                    r.second_text = s[TEXT_W-1:0];
                    // new record goes ahead of every equal key
                    pos = 0;
                    while (pos < rows.size() && rows[pos].key < k)
                        pos++;
                    rows.insert(pos, r);
                end
                owed_beats.push_back(b);
            end
            else if (rows.size() == 0) begin
                b.status = ST_EMPTY;
                owed_beats.push_back(b);
            end
            else begin
                foreach (rows[i]) begin
                    b.status      = ST_RECORD;
                    b.key         = rows[i].key;
                    b.first_text  = rows[i].first_text;
                    b.second_text = rows[i].second_text;
                    b.last        = (i == rows.size() - 1);
                    owed_beats.push_back(b);
                end
            end
        endfunction

        function void check_beat(table_beat_t got);
            table_beat_t want;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat status=%0d key=%0d", $time, got.status, got.key);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.key !== want.key) begin
                $display("%0t: out_key expected %0d actual %0d", $time, want.key, got.key);
                errors++;
            end
            if (got.first_text !== want.first_text) begin
                $display("%0t: out_first_text expected %h actual %h", $time,
                         want.first_text, got.first_text);
                errors++;
            end
            if (got.second_text !== want.second_text) begin
                $display("%0t: out_second_text expected %h actual %h", $time,
                         want.second_text, got.second_text);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_beats.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    logic [IN_TEXT_W-1:0]    first_text;
    logic [IN_TEXT_W-1:0]    second_text;
    logic                    valid;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [IN_TEXT_W-1:0]    out_first_text;
    logic [IN_TEXT_W-1:0]    out_second_text;
    logic                    last;

    record_table_scoreboard sb = new();
    int stall_cycles = 0;

    sorted_insertion_table DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .key             (key),
        .first_text      (first_text),
        .second_text     (second_text),
        .valid           (valid),
        .status          (status),
        .out_key         (out_key),
        .out_first_text  (out_first_text),
        .out_second_text (out_second_text),
        .last            (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result beats are checked as they pass
    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_beat('{status, out_key, out_first_text, out_second_text, last});
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // present one command and hold it until the block takes it
    task automatic issue(input logic c, input logic signed [KEY_W-1:0] k,
                         input logic [IN_TEXT_W-1:0] f, input logic [IN_TEXT_W-1:0] s);
        @(negedge clk);
        start       <= 1'b1;
        cmd         <= c;
        key         <= k;
        first_text  <= f;
        second_text <= s;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c, k, f, s);
    endtask

    // sender gap with junk on the idle fields
    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start       <= 1'b0;
            cmd         <= 1'($urandom);
            key         <= $urandom;
            first_text  <= {$urandom, $urandom};
            second_text <= {$urandom, $urandom};
        end
    endtask

    // hold off until every owed beat is back
    task automatic drain();
        idle(1);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // keys lean toward a few small values so duplicates are common
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, 4) - 2;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic c;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_INSERT;
        key         = '0;
        first_text  = '0;
        second_text = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty read-out, key extremes, equal keys, text patterns
        issue(CMD_READ, 32'sd0, '0, '0);
        issue(CMD_INSERT, 32'sd0, '0, '0);
        issue(CMD_INSERT, 32'h7FFF_FFFF, '1, '1);
        issue(CMD_INSERT, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        issue(CMD_INSERT, -32'sd1, 64'h5A59_0000_004E_4E41, 64'h0000_0000_0000_0042);
        issue(CMD_READ, 32'sd0, '0, '0);
        idle(3);
        // duplicates land ahead of equal keys
        issue(CMD_INSERT, 32'sd0, 64'h0000_0000_0042_4F42, 64'hFF00_0000_0000_00FF);
        issue(CMD_INSERT, 32'h7FFF_FFFF, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321);
        issue(CMD_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000);
        issue(CMD_INSERT, 32'sd1, 64'h4141_4141_4141_4141, 64'h0000_0000_0000_0000);
        issue(CMD_READ, 32'sd0, '0, '0);
        drain();

        // random mix, weighted toward inserts until the table fills
        for (int n = 0; n < ITEM_TARGET; n++) begin
            if (sb.rows.size() < CAPACITY)
                c = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_INSERT;
            else
                c = 1'($urandom);
            issue(c, pick_key(), {$urandom, $urandom}, {$urandom, $urandom});
            if (n == ITEM_TARGET / 2)
                drain();
            else if (n < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle($urandom_range(1, 9));
        end
        idle(1);

        // let the last beats come out
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
